### sv/assert_macros.svh
// Assertion helpers; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BSM_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BSM_ASSERT(label, clk, rst, prop, msg)
`define BSM_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### sv/bsm_pkg.sv
package bsm_pkg;

  localparam int unsigned LIMB_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_ADD   = 3'd4,
    MODE_SUB   = 3'd5
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MULTIPLIER = 1'b0,
    REG_DIVISOR    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EX,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### sv/bsm_ram.sv
module bsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bignum_small_word_mul_div_engine.sv
// One unsigned big number of NUM_LIMBS bytes lives in a single-port-write,
// registered-read RAM (limb 0 is the least significant byte). An item writes
// or reads a limb, multiplies the number by the multiplier register, adds or
// subtracts a 16-bit operand (one RAM read-modify-write per limb, next read
// issued alongside the write), or divides in place by the divisor register
// (a bit-serial restoring divider, walking from the top limb down). One item
// is worked at a time; the result sits in an output register, so a new item
// is taken while it waits. Per-limb valid flops make the number read as zero
// after reset, with no clearing pass. Configuration writes are taken every
// cycle and must only come while idle.
`include "assert_macros.svh"

module bignum_small_word_mul_div_engine #(
  parameter int unsigned NUM_LIMBS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsm_pkg::MODE_W-1:0]        mode,
  input  logic [bsm_pkg::IDX_W-1:0]         limb_index,
  input  logic [bsm_pkg::LIMB_W-1:0]        limb_data,
  input  logic [bsm_pkg::WORD_W-1:0]        operand,
  input  logic                              dividend_is_power,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bsm_pkg::LIMB_W-1:0]        limb_value,
  output logic [bsm_pkg::WORD_W-1:0]        side_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bsm_pkg::WORD_W-1:0]        cfg_data
);
  import bsm_pkg::*;

  localparam int unsigned AW = $clog2(NUM_LIMBS);
  localparam logic [AW-1:0] LAST = AW'(NUM_LIMBS - 1);

  state_t state, state_next;
  mode_t  op_mode, op_mode_next;
  logic [AW-1:0]     cnt, cnt_next;
  logic [2:0]        bitcnt, bitcnt_next;
  logic [WORD_W-1:0] rem, rem_next;
  logic [LIMB_W-1:0] qsh, qsh_next;
  logic [LIMB_W-1:0] res_limb, res_limb_next;
  logic [WORD_W-1:0] operand_q, operand_next;
  logic              power_q, power_next;
  logic [WORD_W-1:0] multiplier, divisor;
  logic [NUM_LIMBS-1:0] vld;
  logic              rd_vld;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [LIMB_W-1:0] mem_wdata, mem_rdata;

  logic              in_acc, in_range, out_load, dsmall, last, advance;
  logic [8:0]        idx_ext;
  logic [AW-1:0]     idx_addr, cnt_adv;
  logic [LIMB_W-1:0] limb_cur, part;
  logic [23:0]       prod, acc;
  logic [9:0]        sum;
  logic [8:0]        subv, diff;
  logic [16:0]       t17;
  logic              ge;

  bsm_ram #(.WIDTH(LIMB_W), .DEPTH(NUM_LIMBS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign idx_ext   = 9'(limb_index);
  assign in_range  = idx_ext < 9'(NUM_LIMBS);
  assign idx_addr  = idx_ext[AW-1:0];
  assign dsmall    = divisor < WORD_W'(2);
  assign last      = (op_mode == MODE_DIV) ? (cnt == '0) : (cnt == LAST);
  assign cnt_adv   = (op_mode == MODE_DIV) ? cnt - AW'(1) : cnt + AW'(1);
  assign limb_cur  = rd_vld ? mem_rdata : '0;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  // per-limb datapath
  assign prod = 24'(limb_cur) * 24'(multiplier);
  assign acc  = prod + 24'(rem);
  assign part = (cnt == AW'(0)) ? operand_q[7:0] :
                (cnt == AW'(1)) ? operand_q[15:8] : '0;
  assign sum  = 10'(limb_cur) + 10'(part) + 10'(rem[0]);
  assign subv = 9'(part) + 9'(rem[0]);
  assign diff = 9'(limb_cur) - subv;
  assign t17  = {rem, qsh[7]};
  assign ge   = t17 >= 17'(divisor);

  always_comb begin
    state_next    = state;
    op_mode_next  = op_mode;
    cnt_next      = cnt;
    bitcnt_next   = bitcnt;
    rem_next      = rem;
    qsh_next      = qsh;
    res_limb_next = res_limb;
    operand_next  = operand_q;
    power_next    = power_q;
    mem_we        = 1'b0;
    mem_waddr     = cnt;
    mem_wdata     = '0;
    mem_raddr     = cnt;
    advance       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          operand_next  = operand;
          power_next    = dividend_is_power;
          res_limb_next = '0;
          rem_next      = '0;
          state_next    = ST_DONE;
          unique case (mode)
            MODE_WRITE: begin
              op_mode_next = MODE_WRITE;
              mem_we       = in_range;
              mem_waddr    = idx_addr;
              mem_wdata    = limb_data;
            end
            MODE_READ: begin
              op_mode_next = MODE_READ;
              mem_raddr    = idx_addr;
              cnt_next     = idx_addr;
              if (in_range) begin
                state_next = ST_EX;
              end
            end
            MODE_MUL, MODE_ADD, MODE_SUB: begin
              op_mode_next = mode_t'(mode);
              cnt_next     = '0;
              mem_raddr    = '0;
              state_next   = ST_EX;
            end
            MODE_DIV: begin
              op_mode_next = MODE_DIV;
              cnt_next     = LAST;
              mem_raddr    = LAST;
              rem_next     = WORD_W'(dividend_is_power && !dsmall);
              state_next   = ST_EX;
            end
            default: begin
              op_mode_next = MODE_WRITE;
            end
          endcase
        end
      end
      ST_EX: begin
        mem_waddr = cnt;
        unique case (op_mode)
          MODE_READ: begin
            res_limb_next = limb_cur;
            state_next    = ST_DONE;
          end
          MODE_MUL: begin
            mem_we    = 1'b1;
            mem_wdata = acc[7:0];
            rem_next  = acc[23:8];
            advance   = 1'b1;
          end
          MODE_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = sum[7:0];
            rem_next  = WORD_W'(sum[8]);
            advance   = 1'b1;
          end
          MODE_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = diff[7:0];
            rem_next  = WORD_W'(9'(limb_cur) < subv);
            advance   = 1'b1;
          end
          MODE_DIV: begin
            if (dsmall) begin
              mem_we    = 1'b1;
              mem_wdata = power_q ? '0 : limb_cur;
              advance   = 1'b1;
            end else begin
              qsh_next    = power_q ? '0 : limb_cur;
              bitcnt_next = '0;
              state_next  = ST_DIV;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DIV: begin
        // one restoring step: shift in the next dividend bit, subtract if it fits
        rem_next    = ge ? 16'(t17 - 17'(divisor)) : t17[15:0];
        qsh_next    = {qsh[6:0], ge};
        bitcnt_next = bitcnt + 3'd1;
        if (bitcnt == 3'd7) begin
          mem_we    = 1'b1;
          mem_waddr = cnt;
          mem_wdata = {qsh[6:0], ge};
          advance   = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // move to the next limb, issuing its read alongside this write
    if (advance) begin
      if (last) begin
        state_next = ST_DONE;
      end else begin
        cnt_next   = cnt_adv;
        mem_raddr  = cnt_adv;
        state_next = ST_EX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      vld        <= '0;
      multiplier <= WORD_W'(1);
      divisor    <= WORD_W'(2);
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_MULTIPLIER: multiplier <= cfg_data;
          REG_DIVISOR:    divisor    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_mode   <= op_mode_next;
    cnt       <= cnt_next;
    bitcnt    <= bitcnt_next;
    rem       <= rem_next;
    qsh       <= qsh_next;
    res_limb  <= res_limb_next;
    operand_q <= operand_next;
    power_q   <= power_next;
    rd_vld    <= vld[mem_raddr];
    if (out_load) begin
      limb_value <= res_limb;
      side_value <= rem;
    end
  end

  `BSM_ASSERT(a_div_write_last_bit, clk, rst,
              (state == ST_DIV && mem_we) |-> (bitcnt == 3'd7),
              "quotient byte written before all eight bits")
  `BSM_ASSERT(a_div_rem_below, clk, rst,
              (state == ST_DIV) |-> (rem < divisor),
              "partial remainder reached the divisor")
  `BSM_ASSERT(a_out_from_done, clk, rst,
              $rose(out_valid) |-> ($past(state) == ST_DONE),
              "result shown without a finished item")
  `BSM_NEVER(a_div_small, clk, rst,
             (state == ST_DIV) && dsmall,
             "bit-serial divide entered with divisor below two")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bsm_pkg::*;

  localparam int unsigned LIMBS      = 32;
  localparam int unsigned ITEM_COUNT = 2000;
  localparam int unsigned MAX_CYCLES = 4000000;
  localparam int unsigned IDLE_PAUSE = 20;
  // Invalid modes; the block answers them with zero and leaves the number alone.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [LIMB_W-1:0] data;
    logic [WORD_W-1:0] operand;
    logic              power;
  } op_item_t;

  typedef struct packed {
    logic [LIMB_W-1:0] limb;
    logic [WORD_W-1:0] side;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [IDX_W-1:0] limb_index = '0;
  logic [LIMB_W-1:0] limb_data = '0;
  logic [WORD_W-1:0] operand = '0;
  logic dividend_is_power = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LIMB_W-1:0] limb_value;
  logic [WORD_W-1:0] side_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;

  bignum_small_word_mul_div_engine #(.NUM_LIMBS(LIMBS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .limb_index(limb_index), .limb_data(limb_data),
    .operand(operand), .dividend_is_power(dividend_is_power),
    .out_valid(out_valid), .out_ready(out_ready),
    .limb_value(limb_value), .side_value(side_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the number and the two registers.
  logic [LIMB_W-1:0] shadow_limbs [LIMBS];
  logic [WORD_W-1:0] shadow_mult;
  logic [WORD_W-1:0] shadow_div;

  op_item_t pending_items[$];
  answer_t  expected_answers[$];

  int unsigned send_idle_pct = 0;  // percent of cycles the sender idles
  int unsigned recv_idle_pct = 0;  // percent of cycles the receiver stalls
  int unsigned recv_hold = 0;      // long receiver hold-off, in cycles
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Set at each rising edge that takes an item, cleared at each rising edge that takes none.
  logic accepted_last = 1'b0;

  logic [WORD_W-1:0] mult_set [5] = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd256};
  logic [WORD_W-1:0] div_set  [5] = '{16'd2, 16'd65535, 16'd1, 16'd7, 16'd0};

  // Work out the answer to one item and advance the shadow number.
  function automatic answer_t bignum_apply(op_item_t it);
    answer_t a;
    logic [31:0] acc, carry, cur, rem, part, sub;
    a = '0;
    carry = 0;
    case (it.mode)
      MODE_WRITE: if (it.idx < LIMBS) shadow_limbs[it.idx] = it.data;
      MODE_READ:  if (it.idx < LIMBS) a.limb = shadow_limbs[it.idx];
      MODE_MUL: begin
        for (int i = 0; i < LIMBS; i++) begin
          acc = shadow_limbs[i] * shadow_mult + carry;
          shadow_limbs[i] = acc[7:0];
          carry = acc >> 8;
        end
        a.side = carry[15:0];
      end
      MODE_DIV: begin
        if (shadow_div < 2) begin
          // Divisor below two acts as one: power dividend wraps to zero.
          if (it.power) for (int i = 0; i < LIMBS; i++) shadow_limbs[i] = '0;
        end else begin
          rem = it.power ? 1 : 0;
          for (int i = LIMBS - 1; i >= 0; i--) begin
            cur = (rem << 8) | (it.power ? 32'd0 : 32'(shadow_limbs[i]));
            shadow_limbs[i] = 8'(cur / shadow_div);
            rem = cur % shadow_div;
          end
          a.side = rem[15:0];
        end
      end
      MODE_ADD: begin
        for (int i = 0; i < LIMBS; i++) begin
          part = (i == 0) ? it.operand[7:0] : (i == 1) ? it.operand[15:8] : 0;
          acc = shadow_limbs[i] + part + carry;
          shadow_limbs[i] = acc[7:0];
          carry = acc >> 8;
        end
        a.side = carry[15:0];
      end
      MODE_SUB: begin
        for (int i = 0; i < LIMBS; i++) begin
          part = (i == 0) ? it.operand[7:0] : (i == 1) ? it.operand[15:8] : 0;
          sub = part + carry;
          acc = shadow_limbs[i] + 256 - sub;
          carry = (shadow_limbs[i] < sub) ? 1 : 0;
          shadow_limbs[i] = acc[7:0];
        end
        a.side = carry[15:0];
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic op_item_t make_item(logic [MODE_W-1:0] m, int unsigned idx,
                                         int unsigned data, int unsigned op,
                                         bit pw);
    op_item_t it;
    it.mode = m;
    it.idx = idx[IDX_W-1:0];
    it.data = data[LIMB_W-1:0];
    it.operand = op[WORD_W-1:0];
    it.power = pw;
    return it;
  endfunction

  // Random item: mostly arithmetic on a filled number, some reads and noise.
  function automatic op_item_t random_item();
    int unsigned pick;
    logic [MODE_W-1:0] m;
    pick = $urandom_range(99);
    if (pick < 20)      m = MODE_WRITE;
    else if (pick < 40) m = MODE_READ;
    else if (pick < 55) m = MODE_MUL;
    else if (pick < 70) m = MODE_DIV;
    else if (pick < 83) m = MODE_ADD;
    else if (pick < 96) m = MODE_SUB;
    else                m = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
    return make_item(m, $urandom_range(31), $urandom_range(255),
                     $urandom_range(3) == 0 ? $urandom_range(1) * 16'hffff
                                            : $urandom_range(65535),
                     $urandom_range(1));
  endfunction

  // Driver: present queued items, hold each until it is accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        // about to be accepted; handled by the monitor
      end
      if (!in_valid || accepted_last) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          mode <= pending_items[0].mode;
          limb_index <= pending_items[0].idx;
          limb_data <= pending_items[0].data;
          operand <= pending_items[0].operand;
          dividend_is_power <= pending_items[0].power;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_hold > 0) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count down the long receiver hold-off.
  always @(posedge clk) begin
    if (recv_hold > 0) recv_hold <= recv_hold - 1;
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    answer_t got, want;
    cycle_count <= cycle_count + 1;
    accepted_last <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_answers.push_back(bignum_apply(make_item(mode, limb_index,
                                   limb_data, operand, dividend_is_power)));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MULTIPLIER) shadow_mult = cfg_data;
        else shadow_div = cfg_data;
      end
      if (out_valid && out_ready) begin
        got.limb = limb_value;
        got.side = side_value;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result limb=%0d side=%0d",
                                         got.limb, got.side);
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: limb exp %0d got %0d, side exp %0d got %0d",
                       want.limb, got.limb, want.side, got.side);
          end
        end
      end
    end
    if (cycle_count >= MAX_CYCLES) begin
      $display("[bignum_small_word_mul_div_engine] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(reg_idx_t r, logic [WORD_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_number(bit extreme);
    for (int i = 0; i < LIMBS; i++)
      pending_items.push_back(make_item(MODE_WRITE, i,
                              extreme ? 255 : $urandom_range(255), 0, 0));
  endtask

  task automatic run_random(int unsigned n);
    int unsigned sent;
    sent = 0;
    while (sent < n) begin
      // Refill now and then so divide and multiply see full-width numbers.
      if ($urandom_range(99) == 0) begin
        fill_number($urandom_range(3) == 0);
        sent += LIMBS;
      end
      pending_items.push_back(random_item());
      sent++;
    end
  endtask

  initial begin
    for (int i = 0; i < LIMBS; i++) shadow_limbs[i] = '0;
    shadow_mult = 16'd1;
    shadow_div = 16'd2;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reads after reset, extremes, every mode, wrap cases.
    send_idle_pct = 21;
    recv_idle_pct = 79;
    pending_items.push_back(make_item(MODE_READ, 31, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SUB, 0, 0, 1, 0));      // underflow
    pending_items.push_back(make_item(MODE_READ, 31, 0, 0, 0));
    pending_items.push_back(make_item(MODE_ADD, 0, 0, 65535, 0));  // overflow
    pending_items.push_back(make_item(MODE_WRITE, 31, 255, 0, 0));
    pending_items.push_back(make_item(MODE_WRITE, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_MUL, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_DIV, 0, 0, 0, 1));      // power dividend
    pending_items.push_back(make_item(MODE_DIV, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SPARE_A, 31, 255, 65535, 1));
    pending_items.push_back(make_item(MODE_SPARE_B, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_ADD, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SUB, 0, 0, 65535, 0));
    wait_drained();

    for (int s = 0; s < 5; s++) begin
      write_reg(REG_MULTIPLIER, mult_set[s]);
      write_reg(REG_DIVISOR, div_set[s]);
      fill_number(s == 1);
      pending_items.push_back(make_item(MODE_MUL, 0, 0, 0, 0));
      pending_items.push_back(make_item(MODE_DIV, 0, 0, 0, 1));
      run_random(ITEM_COUNT / 5 - LIMBS);
      if (s == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 21;
      end
      if (s == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Block fills up behind a stalled receiver while items keep coming.
        @(negedge clk);
        recv_hold = 400;
      end
      // Sender pauses until every outstanding result is back.
      wait_drained();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[bignum_small_word_mul_div_engine] OK");
    end else begin
      $display("[bignum_small_word_mul_div_engine] ERROR");
    end
    $finish;
  end

endmodule
